// ----- src/rkf_pkg.sv -----
// Package for the range Kalman filter core: shared constants, FSM and
// operation codes, register indexes and saturation helpers.
// No dependencies.
package rkf_pkg;

  localparam int unsigned COV_FRAC_BITS_DEF = 16;
  localparam int unsigned GAIN_FRAC = 20;
  localparam int unsigned DIV_STEPS = 30;

  // Configuration register indexes (byte address / 4)
  localparam logic [2:0] REG_OUTLIER_CHECK_ON = 3'd0;
  localparam logic [2:0] REG_OUTLIER_LIMIT    = 3'd1;
  localparam logic [2:0] REG_MEAS_NOISE_VAR   = 3'd2;
  localparam logic [2:0] REG_ACCEL_DEVIATION  = 3'd3;
  localparam logic [2:0] REG_INITIAL_VARIANCE = 3'd4;

  // Register reset values
  localparam logic [15:0] OUTLIER_LIMIT_RST    = 16'd512;
  localparam logic [23:0] MEAS_NOISE_VAR_RST   = 24'd11520;
  localparam logic [15:0] ACCEL_DEVIATION_RST  = 16'd700;
  localparam logic [15:0] INITIAL_VARIANCE_RST = 16'd100;

  localparam logic [47:0] Q22_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [29:0] GAIN_MAX = 30'h3FFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MH,    // multiply by the high half of the wide operand
    ST_ML,    // multiply by the low half
    ST_MW,    // combine and write back
    ST_PREP,  // predicted covariance
    ST_GATE,  // innovation variance and gating
    ST_DIVI,  // gain division set-up
    ST_DIV,   // one quotient bit per cycle
    ST_DONE
  } state_t;

  // velocity correction runs before the position one, so both see the
  // innovation against the predicted position
  typedef enum logic [3:0] {
    OP_VT,
    OP_TA,
    OP_SQ,
    OP_Q12,
    OP_Q11,
    OP_A,
    OP_B,
    OP_C,
    OP_KY2,
    OP_KY1,
    OP_M1,
    OP_M2,
    OP_M3
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    logic signed [47:0] r;
    if (x > 64'sh0000_7FFF_FFFF_FFFF) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (x < -64'sh0000_8000_0000_0000) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

endpackage

// ----- src/range_kalman_filter_pos_vel_core.sv -----
// Top level of the range Kalman filter core (position/velocity tracker).
// Depends on rkf_pkg.
//
// Two-state constant-velocity Kalman filter for a stream of range items.
// An item with start_over set loads the state and goes straight to ST_DONE; any
// other item runs a micro-sequence on one shared 33x25 signed multiplier (each
// wide product is built in the MH, ML and MW states) and a bit-serial divider for
// the two gains, which a gated or skipped update leaves out. in_tready is high
// only while the sequencer is idle; a finished result waits in the output register
// while the next item is taken in, whose result waits for that register. The user
// must see that configuration is written through the APB-style port only while
// the block is idle; the block does not enforce this. pready is always high.
module range_kalman_filter_pos_vel_core
  import rkf_pkg::*;
#(
  parameter int unsigned COV_FRAC_BITS = rkf_pkg::COV_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // measured_range[23:0], time_step[39:24], link_quality[55:40]
  input  logic        in_tuser,   // start_over
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // position_est[31:0], velocity_est[63:32]
  output logic        out_tuser,  // measurement_used
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SQ_SH = 32 - COV_FRAC_BITS;
  localparam int unsigned R_SH  = COV_FRAC_BITS - 8;

  // config registers
  logic        outlier_check_on_r;
  logic [15:0] outlier_limit_r;
  logic [23:0] meas_noise_var_r;
  logic [15:0] accel_deviation_r;
  logic [15:0] initial_variance_r;

  // control
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [4:0] div_cnt_r, div_cnt_nxt;
  logic       div_sel_r, div_sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  // item and filter state
  logic [23:0] z_r, z_nxt;
  logic [15:0] t_r, t_nxt;
  logic [15:0] lq_r, lq_nxt;
  logic signed [31:0] pos_r, pos_nxt, vel_r, vel_nxt;
  logic signed [47:0] cov_pos_r, cov_pos_nxt, cov_cross_r, cov_cross_nxt;
  logic signed [47:0] cov_vel_r, cov_vel_nxt;
  logic        used_r, used_nxt;

  // intermediates
  logic [31:0] ta_r, ta_nxt;
  logic signed [47:0] q22_r, q22_nxt, q12_r, q12_nxt, q11_r, q11_nxt;
  logic signed [47:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic signed [47:0] p11_r, p11_nxt, p12_r, p12_nxt, p22_r, p22_nxt;
  logic signed [49:0] s_r, s_nxt;
  logic signed [30:0] k1_r, k1_nxt, k2_r, k2_nxt;
  logic signed [57:0] prod_r, prod_nxt;
  logic signed [81:0] acc_r, acc_nxt;
  logic [49:0] rem_r, rem_nxt;
  logic [29:0] dq_r, dq_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic        out_used_r, out_used_nxt;

  // combinational
  logic in_acc, out_acc, cfg_wr, upd_go, do_load;
  logic signed [32:0] y;
  logic signed [32:0] m_s;
  logic signed [47:0] m_b;
  logic signed [24:0] mul_b;
  logic signed [81:0] full, f16, f17, f20;
  logic [81:0] fsq;
  logic signed [49:0] s_calc;
  logic signed [47:0] dnum;
  logic [47:0] dmag;
  logic [48:0] dden;
  logic [49:0] r2;
  logic        qbit;
  logic [29:0] qfin;
  logic signed [30:0] kfin;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_valid_r && out_tready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // register read-back
  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_OUTLIER_CHECK_ON: cfg_prdata = {31'd0, outlier_check_on_r};
      REG_OUTLIER_LIMIT:    cfg_prdata = {16'd0, outlier_limit_r};
      REG_MEAS_NOISE_VAR:   cfg_prdata = {8'd0, meas_noise_var_r};
      REG_ACCEL_DEVIATION:  cfg_prdata = {16'd0, accel_deviation_r};
      REG_INITIAL_VARIANCE: cfg_prdata = {16'd0, initial_variance_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // innovation against the predicted position
  assign y = signed'({9'd0, z_r}) - 33'(pos_r);

  // shared multiplier operand selection
  always_comb begin
    m_s = signed'({17'd0, t_r});
    m_b = 48'(vel_r);
    unique case (op_r)
      OP_VT:  m_b = 48'(vel_r);
      OP_TA:  m_b = signed'({32'd0, accel_deviation_r});
      OP_SQ:  begin
        m_s = signed'({1'b0, ta_r});
        m_b = signed'({16'd0, ta_r});
      end
      OP_Q12: m_b = q22_r;
      OP_Q11: m_b = q12_r;
      OP_A:   m_b = cov_cross_r;
      OP_B:   m_b = cov_vel_r;
      OP_C:   m_b = b_r;
      OP_KY1: begin
        m_s = y;
        m_b = 48'(k1_r);
      end
      OP_KY2: begin
        m_s = y;
        m_b = 48'(k2_r);
      end
      OP_M1:  begin
        m_s = 33'(k1_r);
        m_b = p11_r;
      end
      OP_M2:  begin
        m_s = 33'(k1_r);
        m_b = p12_r;
      end
      OP_M3:  begin
        m_s = 33'(k2_r);
        m_b = p12_r;
      end
      default: m_b = 48'(vel_r);
    endcase
  end

  // high half signed, low half unsigned
  assign mul_b = (state_r == ST_MH) ? signed'({m_b[47], m_b[47:24]})
                                    : signed'({1'b0, m_b[23:0]});

  // wide product: high part (already shifted into acc_r) plus low part
  assign full = acc_r + signed'({{24{prod_r[57]}}, prod_r});
  assign f16  = full >>> 16;
  assign f17  = full >>> 17;
  assign f20  = full >>> GAIN_FRAC;
  assign fsq  = full >> SQ_SH;

  // innovation variance and gate
  assign s_calc = 50'(p11_r) + signed'(50'(meas_noise_var_r) << R_SH);
  assign upd_go = !(outlier_check_on_r && (lq_r >= outlier_limit_r)) && (s_calc > 50'sd0);

  // divider step
  assign dnum = div_sel_r ? p12_r : p11_r;
  assign dmag = dnum[47] ? 48'(-dnum) : dnum;
  assign dden = s_r[48:0];
  assign r2   = {rem_r[48:0], dq_r[29]};
  assign qbit = (r2 >= {1'b0, dden});
  assign qfin = {dq_r[28:0], qbit};

  always_comb begin
    logic [29:0] qsel;
    qsel = (state_r == ST_DIVI) ? GAIN_MAX : qfin;
    kfin = dnum[47] ? -signed'({1'b0, qsel}) : signed'({1'b0, qsel});
  end

  assign do_load = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser ? ST_DONE : ST_MH;
        end
      end
      ST_MH: state_nxt = ST_ML;
      ST_ML: state_nxt = ST_MW;
      ST_MW: begin
        if (op_r == OP_C) begin
          state_nxt = ST_PREP;
        end else if (op_r == OP_M3) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MH;
        end
      end
      ST_PREP: state_nxt = ST_GATE;
      ST_GATE: state_nxt = upd_go ? ST_DIVI : ST_DONE;
      ST_DIVI: begin
        if ({11'd0, dmag} >= {dden, 10'd0}) begin
          state_nxt = div_sel_r ? ST_MH : ST_DIVI;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == 5'd1) begin
          state_nxt = div_sel_r ? ST_MH : ST_DIVI;
        end
      end
      ST_DONE: begin
        if (do_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
    out_tuser  = out_used_r;
  end

  // datapath
  always_comb begin
    op_nxt = op_r;  div_cnt_nxt = div_cnt_r;  div_sel_nxt = div_sel_r;
    z_nxt = z_r;  t_nxt = t_r;  lq_nxt = lq_r;
    pos_nxt = pos_r;  vel_nxt = vel_r;
    cov_pos_nxt = cov_pos_r;  cov_cross_nxt = cov_cross_r;  cov_vel_nxt = cov_vel_r;
    used_nxt = used_r;
    ta_nxt = ta_r;  q22_nxt = q22_r;  q12_nxt = q12_r;  q11_nxt = q11_r;
    a_nxt = a_r;  b_nxt = b_r;  c_nxt = c_r;
    p11_nxt = p11_r;  p12_nxt = p12_r;  p22_nxt = p22_r;  s_nxt = s_r;
    k1_nxt = k1_r;  k2_nxt = k2_r;
    prod_nxt = m_s * mul_b;
    acc_nxt = acc_r;
    rem_nxt = rem_r;  dq_nxt = dq_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;  out_used_nxt = out_used_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          z_nxt    = in_tdata[23:0];
          t_nxt    = in_tdata[39:24];
          lq_nxt   = in_tdata[55:40];
          used_nxt = 1'b0;
          op_nxt   = OP_VT;
          if (in_tuser) begin
            pos_nxt       = signed'({8'd0, in_tdata[23:0]});
            vel_nxt       = 32'sd0;
            cov_pos_nxt   = signed'(48'(initial_variance_r) << COV_FRAC_BITS);
            cov_vel_nxt   = signed'(48'(initial_variance_r) << COV_FRAC_BITS);
            cov_cross_nxt = 48'sd0;
          end
        end
      end
      ST_MH: ;
      ST_ML: acc_nxt = {prod_r, 24'd0};
      ST_MW: begin
        op_nxt = op_t'(op_r + 4'd1);
        unique case (op_r)
          OP_VT:  pos_nxt = sat32(64'(pos_r) + signed'(f16[63:0]));
          OP_TA:  ta_nxt = full[31:0];
          OP_SQ:  q22_nxt = (fsq > 82'(Q22_MAX)) ? signed'(Q22_MAX) : signed'(fsq[47:0]);
          OP_Q12: q12_nxt = f17[47:0];
          OP_Q11: q11_nxt = f17[47:0];
          OP_A:   a_nxt = f16[47:0];
          OP_B:   b_nxt = f16[47:0];
          OP_C:   c_nxt = f16[47:0];
          OP_KY1: pos_nxt = sat32(64'(pos_r) + signed'(f20[63:0]));
          OP_KY2: vel_nxt = sat32(64'(vel_r) + signed'(f20[63:0]));
          OP_M1:  cov_pos_nxt = sat48(64'(p11_r) - signed'(f20[63:0]));
          OP_M2:  cov_cross_nxt = sat48(64'(p12_r) - signed'(f20[63:0]));
          OP_M3:  begin
            cov_vel_nxt = sat48(64'(p22_r) - signed'(f20[63:0]));
            used_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      ST_PREP: begin
        p11_nxt = sat48(64'(cov_pos_r) + 64'(a_r) + 64'(a_r) + 64'(c_r) + 64'(q11_r));
        p12_nxt = sat48(64'(cov_cross_r) + 64'(b_r) + 64'(q12_r));
        p22_nxt = sat48(64'(cov_vel_r) + 64'(q22_r));
      end
      ST_GATE: begin
        s_nxt = s_calc;
        div_sel_nxt = 1'b0;
        if (!upd_go) begin
          cov_pos_nxt   = p11_r;
          cov_cross_nxt = p12_r;
          cov_vel_nxt   = p22_r;
        end
      end
      ST_DIVI: begin
        if ({11'd0, dmag} >= {dden, 10'd0}) begin
          // quotient would exceed the gain range: saturate
          if (div_sel_r) begin
            k2_nxt = kfin;
            op_nxt = OP_KY2;
          end else begin
            k1_nxt = kfin;
            div_sel_nxt = 1'b1;
          end
        end else begin
          rem_nxt = {12'd0, dmag[47:10]};
          dq_nxt  = {dmag[9:0], 20'd0};
          div_cnt_nxt = 5'(DIV_STEPS);
        end
      end
      ST_DIV: begin
        rem_nxt = qbit ? (r2 - {1'b0, dden}) : r2;
        dq_nxt  = qfin;
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd1) begin
          if (div_sel_r) begin
            k2_nxt = kfin;
            op_nxt = OP_KY2;
          end else begin
            k1_nxt = kfin;
            div_sel_nxt = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (do_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {vel_r, pos_r};
          out_used_nxt  = used_r;
        end
      end
      default: ;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outlier_check_on_r <= 1'b0;
      outlier_limit_r    <= OUTLIER_LIMIT_RST;
      meas_noise_var_r   <= MEAS_NOISE_VAR_RST;
      accel_deviation_r  <= ACCEL_DEVIATION_RST;
      initial_variance_r <= INITIAL_VARIANCE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_OUTLIER_CHECK_ON: outlier_check_on_r <= cfg_pwdata[0];
        REG_OUTLIER_LIMIT:    outlier_limit_r    <= cfg_pwdata[15:0];
        REG_MEAS_NOISE_VAR:   meas_noise_var_r   <= cfg_pwdata[23:0];
        REG_ACCEL_DEVIATION:  accel_deviation_r  <= cfg_pwdata[15:0];
        REG_INITIAL_VARIANCE: initial_variance_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_VT;
      div_cnt_r   <= 5'd0;
      div_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= 32'sd0;
      vel_r       <= 32'sd0;
      cov_pos_r   <= 48'sd0;
      cov_cross_r <= 48'sd0;
      cov_vel_r   <= 48'sd0;
      used_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_sel_r   <= div_sel_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      cov_pos_r   <= cov_pos_nxt;
      cov_cross_r <= cov_cross_nxt;
      cov_vel_r   <= cov_vel_nxt;
      used_r      <= used_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    z_r <= z_nxt;  t_r <= t_nxt;  lq_r <= lq_nxt;
    ta_r <= ta_nxt;  q22_r <= q22_nxt;  q12_r <= q12_nxt;  q11_r <= q11_nxt;
    a_r <= a_nxt;  b_r <= b_nxt;  c_r <= c_nxt;
    p11_r <= p11_nxt;  p12_r <= p12_nxt;  p22_r <= p22_nxt;  s_r <= s_nxt;
    k1_r <= k1_nxt;  k2_r <= k2_nxt;
    prod_r <= prod_nxt;  acc_r <= acc_nxt;
    rem_r <= rem_nxt;  dq_r <= dq_nxt;
    out_data_r <= out_data_nxt;  out_used_r <= out_used_nxt;
  end

  // checks
  a_start_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> (state_r == ST_DONE))
    else $error("initialise item did not go straight to result");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r != 5'd0))
    else $error("divider running with zero step count");

  a_gate_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GATE && !upd_go) |=> (state_r == ST_DONE && !used_r))
    else $error("skipped update did not finish at once");

endmodule
